// File: hw/rtl/gcode_plane_rotation_macros.svh
// Assertion macros shared by the plane rotation checker
`ifndef GCODE_PLANE_ROTATION_MACROS_SVH
`define GCODE_PLANE_ROTATION_MACROS_SVH

// same-cycle implication, quiet during reset
`define GPR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define GPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define GPR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gpr_pkg.sv
// Types, constants and helpers for the plane rotation block
`default_nettype none
package gpr_pkg;

   localparam int TRIG_FRAC   = 16;
   localparam int TRIG_W      = TRIG_FRAC + 2;
   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = DIFF_W + TRIG_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int RND_W       = SUM_W - TRIG_FRAC;
   localparam int LANE_STAGES = 5;
   localparam int LIMIT_W     = 16;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_ORDINARY = 2'd0;
   localparam cmd_type CMD_START    = 2'd1;
   localparam cmd_type CMD_STOP     = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_NO_FIRST    = 3'd1;
   localparam status_type ST_NO_SECOND   = 3'd2;
   localparam status_type ST_NO_ANGLE    = 3'd3;
   localparam status_type ST_ANGLE_RANGE = 3'd4;

   localparam logic signed [COORD_W-1:0] ANGLE_MAX = 32'sd23592960;
   localparam logic signed [COORD_W-1:0] ANGLE_MIN = -32'sd23592960;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [TRIG_W-1:0] sine;
      logic signed [TRIG_W-1:0] cosine;
   } trig_result_type;

   typedef struct packed {
      logic                      rot;
      logic signed [COORD_W-1:0] center_h;
      logic signed [COORD_W-1:0] center_v;
      logic signed [TRIG_W-1:0]  cosine;
      logic signed [TRIG_W-1:0]  sine;
   } lane_ctrl_type;

   typedef struct packed {
      logic [5:0]  shift;
      logic [31:0] mult;
   } recip_type;

   // reciprocal of the n(n+1) divisor for step k, exact for dividends below 2^31
   function automatic recip_type series_recip(input logic is_cos, input logic [2:0] k);
      recip_type r;
      r.shift = 6'd31;
      r.mult  = 32'h8000_0000;
      if (is_cos) begin
         case (k)
            3'd1: begin
               r.shift = 6'd32;
               r.mult  = 32'(((64'd1 << 32) + 64'd1) / 64'd2);
            end
            3'd2: begin
               r.shift = 6'd35;
               r.mult  = 32'(((64'd1 << 35) + 64'd11) / 64'd12);
            end
            3'd3: begin
               r.shift = 6'd36;
               r.mult  = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
            end
            3'd4: begin
               r.shift = 6'd37;
               r.mult  = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
            end
            3'd5: begin
               r.shift = 6'd38;
               r.mult  = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
            end
            default: begin
               r.shift = 6'd31;
               r.mult  = 32'h8000_0000;
            end
         endcase
      end else begin
         case (k)
            3'd1: begin
               r.shift = 6'd34;
               r.mult  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
            end
            3'd2: begin
               r.shift = 6'd36;
               r.mult  = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
            end
            3'd3: begin
               r.shift = 6'd37;
               r.mult  = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
            end
            3'd4: begin
               r.shift = 6'd38;
               r.mult  = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
            end
            default: begin
               r.shift = 6'd31;
               r.mult  = 32'h8000_0000;
            end
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gpr_trig.sv
// Sequential sine/cosine generator: one shared multiplier, reciprocal division
`default_nettype none
module gpr_trig import gpr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [COORD_W-1:0] angle,
   output trig_result_type                result
);

   localparam logic signed [32:0] FULL    = 33'sd23592960;
   localparam logic signed [32:0] QUARTER = 33'sd5898240;
   localparam logic signed [32:0] EIGHTH  = 33'sd2949120;
   localparam logic [31:0]        PI_Q30  = 32'hC90FDAA2;
   // ceil(pi_q30 * 2^26 / 45): x = r * X_RCP >> 44
   localparam logic [63:0]        X_RCP   = ((64'(PI_Q30) << 26) + 64'd44) / 64'd45;
   localparam int                 ACC_W   = 34;
   localparam int                 RND_SH  = 30 - TRIG_FRAC;
   localparam logic signed [ACC_W-1:0] RND_HALF =
      ACC_W'(RND_SH == 0 ? 0 : 2 ** (RND_SH - 1));
   localparam logic [30:0]        Q30_ONE = 31'h4000_0000;

   typedef enum logic [9:0] {
      T_IDLE = 10'b00_0000_0001,
      T_WRAP = 10'b00_0000_0010,
      T_FOLD = 10'b00_0000_0100,
      T_XMUL = 10'b00_0000_1000,
      T_XHI  = 10'b00_0001_0000,
      T_MUL1 = 10'b00_0010_0000,
      T_MUL2 = 10'b00_0100_0000,
      T_DIV  = 10'b00_1000_0000,
      T_ACC  = 10'b01_0000_0000,
      T_DONE = 10'b10_0000_0000
   } tstate_type;

   tstate_type              state_ff, state_in;
   logic signed [32:0]      ang_ff, ang_in;
   logic [1:0]              quad_ff, quad_in;
   logic                    swap_ff, swap_in;
   logic [22:0]             r_ff, r_in;
   logic [29:0]             x_ff, x_in;
   logic [30:0]             term_ff, term_in;
   logic [63:0]             prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] sacc_ff, sacc_in;
   logic [2:0]              k_ff, k_in;
   logic                    cos_phase_ff, cos_phase_in;
   logic [30:0]             n_ff, n_in;

   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mul_p;
   recip_type               rcp;
   logic [63:0]             div_q;
   logic [63:0]             x_sum;
   logic signed [32:0]      wrap_a, wrap_b;
   logic [1:0]              fold_q;
   logic signed [32:0]      fold_off, fold_r;
   logic                    fold_swap;
   logic signed [ACC_W-1:0] acc_new;
   logic signed [ACC_W-1:0] s_sum, c_sum;
   logic signed [TRIG_W-1:0] s_rnd, c_rnd, s_sw, c_sw;

   assign rcp = series_recip(cos_phase_ff, k_ff);

   always_comb begin
      case (state_ff)
         T_XMUL: begin
            mul_a = {9'd0, r_ff};
            mul_b = {6'd0, X_RCP[25:0]};
         end
         T_XHI: begin
            mul_a = {9'd0, r_ff};
            mul_b = {5'd0, X_RCP[52:26]};
         end
         T_MUL1: begin
            mul_a = {1'b0, term_ff};
            mul_b = {2'b0, x_ff};
         end
         T_MUL2: begin
            mul_a = {1'b0, prod_ff[60:30]};
            mul_b = {2'b0, x_ff};
         end
         T_DIV: begin
            mul_a = {1'b0, n_ff};
            mul_b = rcp.mult;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign div_q = mul_p >> rcp.shift;
   assign x_sum = mul_p + {26'd0, prod_ff[63:26]};

   assign wrap_a = (ang_ff < 0) ? ang_ff + FULL : ang_ff;
   assign wrap_b = (wrap_a >= FULL) ? wrap_a - FULL : wrap_a;

   always_comb begin
      if (ang_ff >= 3 * QUARTER) begin
         fold_q   = 2'd3;
         fold_off = 33'(3 * QUARTER);
      end else if (ang_ff >= 2 * QUARTER) begin
         fold_q   = 2'd2;
         fold_off = 33'(2 * QUARTER);
      end else if (ang_ff >= QUARTER) begin
         fold_q   = 2'd1;
         fold_off = QUARTER;
      end else begin
         fold_q   = 2'd0;
         fold_off = '0;
      end
   end
   assign fold_r    = ang_ff - fold_off;
   assign fold_swap = fold_r > EIGHTH;

   assign acc_new = k_ff[0] ? acc_ff - $signed({3'd0, term_ff})
                            : acc_ff + $signed({3'd0, term_ff});

   always_comb begin
      state_in     = state_ff;
      ang_in       = ang_ff;
      quad_in      = quad_ff;
      swap_in      = swap_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      term_in      = term_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sacc_in      = sacc_ff;
      k_in         = k_ff;
      cos_phase_in = cos_phase_ff;
      n_in         = n_ff;
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               ang_in   = {angle[COORD_W-1], angle};
               state_in = T_WRAP;
            end
         end
         T_WRAP: begin
            ang_in   = wrap_b;
            state_in = T_FOLD;
         end
         T_FOLD: begin
            quad_in  = fold_q;
            swap_in  = fold_swap;
            r_in     = fold_swap ? 23'(QUARTER - fold_r) : fold_r[22:0];
            state_in = T_XMUL;
         end
         T_XMUL: begin
            prod_in  = mul_p;
            state_in = T_XHI;
         end
         T_XHI: begin
            x_in         = x_sum[47:18];
            term_in      = {1'b0, x_sum[47:18]};
            acc_in       = $signed({4'd0, x_sum[47:18]});
            k_in         = 3'd1;
            cos_phase_in = 1'b0;
            state_in     = T_MUL1;
         end
         T_MUL1: begin
            prod_in  = mul_p;
            state_in = T_MUL2;
         end
         T_MUL2: begin
            n_in     = mul_p[60:30];
            state_in = T_DIV;
         end
         T_DIV: begin
            term_in  = div_q[30:0];
            state_in = T_ACC;
         end
         T_ACC: begin
            k_in   = k_ff + 1'b1;
            acc_in = acc_new;
            if (!cos_phase_ff && k_ff == 3'd4) begin
               sacc_in      = acc_new;
               term_in      = Q30_ONE;
               acc_in       = $signed({3'd0, Q30_ONE});
               k_in         = 3'd1;
               cos_phase_in = 1'b1;
               state_in     = T_MUL1;
            end else if (cos_phase_ff && k_ff == 3'd5) begin
               state_in = T_DONE;
            end else begin
               state_in = T_MUL1;
            end
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ang_ff       <= ang_in;
      quad_ff      <= quad_in;
      swap_ff      <= swap_in;
      r_ff         <= r_in;
      x_ff         <= x_in;
      term_ff      <= term_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      sacc_ff      <= sacc_in;
      k_ff         <= k_in;
      cos_phase_ff <= cos_phase_in;
      n_ff         <= n_in;
   end

   // round half up to the trig format, then undo fold and quadrant
   assign s_sum = (sacc_ff + RND_HALF) >>> RND_SH;
   assign c_sum = (acc_ff + RND_HALF) >>> RND_SH;
   assign s_rnd = s_sum[TRIG_W-1:0];
   assign c_rnd = c_sum[TRIG_W-1:0];
   assign s_sw  = swap_ff ? c_rnd : s_rnd;
   assign c_sw  = swap_ff ? s_rnd : c_rnd;

   always_comb begin
      result.busy = state_ff != T_IDLE;
      result.done = state_ff == T_DONE;
      case (quad_ff)
         2'd0: begin
            result.sine   = s_sw;
            result.cosine = c_sw;
         end
         2'd1: begin
            result.sine   = c_sw;
            result.cosine = -s_sw;
         end
         2'd2: begin
            result.sine   = -s_sw;
            result.cosine = -c_sw;
         end
         default: begin
            result.sine   = -c_sw;
            result.cosine = s_sw;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/gpr_lane.sv
// One rotation lane: rotates a point about the stored centre, snap and saturate
`default_nettype none
module gpr_lane import gpr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic signed [COORD_W-1:0] point_h,
   input  wire logic signed [COORD_W-1:0] point_v,
   input  wire lane_ctrl_type             ctrl,
   input  wire logic [LIMIT_W-1:0]        limit,
   output logic signed [COORD_W-1:0]      out_h,
   output logic signed [COORD_W-1:0]      out_v
);

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(2 ** (TRIG_FRAC - 1));

   // stage A
   logic signed [COORD_W-1:0] h_a_ff, v_a_ff, ch_a_ff, cv_a_ff;
   logic                      rot_a_ff;
   logic signed [DIFF_W-1:0]  dh_a_ff, dv_a_ff, dh_in, dv_in;
   logic signed [TRIG_W-1:0]  cos_a_ff, sin_a_ff;
   // stage B
   logic signed [COORD_W-1:0] h_b_ff, v_b_ff, ch_b_ff, cv_b_ff;
   logic                      rot_b_ff;
   logic signed [PROD_W-1:0]  hc_b_ff, vs_b_ff, hs_b_ff, vc_b_ff;
   logic signed [PROD_W-1:0]  hc_in, vs_in, hs_in, vc_in;
   // stage C
   logic signed [COORD_W-1:0] h_c_ff, v_c_ff, ch_c_ff, cv_c_ff;
   logic                      rot_c_ff;
   logic signed [SUM_W-1:0]   sh_in, sv_in;
   logic signed [RND_W-1:0]   nh_c_ff, nv_c_ff;
   // stage D
   logic signed [COORD_W-1:0] h_d_ff, v_d_ff, ch_d_ff, cv_d_ff;
   logic                      rot_d_ff;
   logic signed [RND_W-1:0]   mh_in, mv_in, nh_d_ff, nv_d_ff, ph_in, pv_in;
   // stage E
   logic signed [RND_W:0]     th_in, tv_in;
   logic signed [COORD_W-1:0] oh_in, ov_in, out_h_ff, out_v_ff;

   assign dh_in = DIFF_W'(point_h) - DIFF_W'(ctrl.center_h);
   assign dv_in = DIFF_W'(point_v) - DIFF_W'(ctrl.center_v);

   assign hc_in = dh_a_ff * cos_a_ff;
   assign vs_in = dv_a_ff * sin_a_ff;
   assign hs_in = dh_a_ff * sin_a_ff;
   assign vc_in = dv_a_ff * cos_a_ff;

   assign sh_in = SUM_W'(hc_b_ff) - SUM_W'(vs_b_ff) + HALF;
   assign sv_in = SUM_W'(hs_b_ff) + SUM_W'(vc_b_ff) + HALF;

   assign mh_in = nh_c_ff[RND_W-1] ? -nh_c_ff : nh_c_ff;
   assign mv_in = nv_c_ff[RND_W-1] ? -nv_c_ff : nv_c_ff;
   assign ph_in = (mh_in < $signed(RND_W'(limit))) ? '0 : nh_c_ff;
   assign pv_in = (mv_in < $signed(RND_W'(limit))) ? '0 : nv_c_ff;

   assign th_in = (RND_W + 1)'(nh_d_ff) + (RND_W + 1)'(ch_d_ff);
   assign tv_in = (RND_W + 1)'(nv_d_ff) + (RND_W + 1)'(cv_d_ff);

   always_comb begin
      if (!rot_d_ff) begin
         oh_in = h_d_ff;
      end else if (th_in[RND_W:COORD_W-1] != '0 && th_in[RND_W:COORD_W-1] != '1) begin
         oh_in = th_in[RND_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         oh_in = th_in[COORD_W-1:0];
      end
      if (!rot_d_ff) begin
         ov_in = v_d_ff;
      end else if (tv_in[RND_W:COORD_W-1] != '0 && tv_in[RND_W:COORD_W-1] != '1) begin
         ov_in = tv_in[RND_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         ov_in = tv_in[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_a_ff   <= point_h;
         v_a_ff   <= point_v;
         ch_a_ff  <= ctrl.center_h;
         cv_a_ff  <= ctrl.center_v;
         rot_a_ff <= ctrl.rot;
         dh_a_ff  <= dh_in;
         dv_a_ff  <= dv_in;
         cos_a_ff <= ctrl.cosine;
         sin_a_ff <= ctrl.sine;

         h_b_ff   <= h_a_ff;
         v_b_ff   <= v_a_ff;
         ch_b_ff  <= ch_a_ff;
         cv_b_ff  <= cv_a_ff;
         rot_b_ff <= rot_a_ff;
         hc_b_ff  <= hc_in;
         vs_b_ff  <= vs_in;
         hs_b_ff  <= hs_in;
         vc_b_ff  <= vc_in;

         h_c_ff   <= h_b_ff;
         v_c_ff   <= v_b_ff;
         ch_c_ff  <= ch_b_ff;
         cv_c_ff  <= cv_b_ff;
         rot_c_ff <= rot_b_ff;
         nh_c_ff  <= sh_in[SUM_W-1:TRIG_FRAC];
         nv_c_ff  <= sv_in[SUM_W-1:TRIG_FRAC];

         h_d_ff   <= h_c_ff;
         v_d_ff   <= v_c_ff;
         ch_d_ff  <= ch_c_ff;
         cv_d_ff  <= cv_c_ff;
         rot_d_ff <= rot_c_ff;
         nh_d_ff  <= ph_in;
         nv_d_ff  <= pv_in;

         out_h_ff <= oh_in;
         out_v_ff <= ov_in;
      end
   end

   assign out_h = out_h_ff;
   assign out_v = out_v_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gcode_plane_rotation.sv
// Top level of the G68-style plane rotation block
//
// Requests arrive on req_* (valid/stall) carrying one parsed motion block each;
// results leave on rsp_* (valid/stall), one per request, in request order.
// csr_valid/csr_ready writes the near-zero limit; csr_ready is always high and
// the register should only be written while no request is in flight.
// Ordinary and stop blocks are taken one per cycle while req_stall is low:
// two lanes rotate the target and arc points in a five-stage pipeline and a
// merging register joins them with the status. A valid start block holds
// req_stall high after acceptance while the trig unit runs its Taylor series
// through one shared multiplier, dividing by reciprocal multiplication;
// failed start blocks do not hold req_stall.
// When rsp_stall holds a waiting result, the pipeline runs on until one more
// result lands in a holding register; then it freezes and req_stall is high
// from the next cycle until the waiting result is taken.
// Reset (synchronous) turns rotation off, sets the centre to zero, cosine to
// one, sine to zero, the near-zero limit to one and empties the pipeline.
`default_nettype none
module gcode_plane_rotation import gpr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_command,
   input  wire logic signed [COORD_W-1:0] req_target_h,
   input  wire logic signed [COORD_W-1:0] req_target_v,
   input  wire logic signed [COORD_W-1:0] req_arc_h,
   input  wire logic signed [COORD_W-1:0] req_arc_v,
   input  wire logic signed [COORD_W-1:0] req_center_first,
   input  wire logic signed [COORD_W-1:0] req_center_second,
   input  wire logic signed [COORD_W-1:0] req_angle_degrees,
   input  wire logic                      req_has_center_first,
   input  wire logic                      req_has_center_second,
   input  wire logic                      req_has_angle,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [COORD_W-1:0]      rsp_out_target_h,
   output logic signed [COORD_W-1:0]      rsp_out_target_v,
   output logic signed [COORD_W-1:0]      rsp_out_arc_h,
   output logic signed [COORD_W-1:0]      rsp_out_arc_v,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_rotating,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [LIMIT_W-1:0]        csr_near_zero_limit
);

   logic                      rotation_on_ff, rotation_on_in;
   logic signed [COORD_W-1:0] center_h_ff, center_v_ff;
   logic signed [TRIG_W-1:0]  cos_ff, sin_ff;
   logic [LIMIT_W-1:0]        limit_ff;

   logic [LANE_STAGES-1:0]    vld_ff;
   status_type                st_ff [LANE_STAGES];
   logic [LANE_STAGES-1:0]    rotg_ff;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] th_ff, tv_ff, ah_ff, av_ff;
   status_type                rsp_st_ff;
   logic                      rsp_rotg_ff;

   logic                      skid_vld_ff;
   logic signed [COORD_W-1:0] sk_th_ff, sk_tv_ff, sk_ah_ff, sk_av_ff;
   status_type                sk_st_ff;
   logic                      sk_rotg_ff;

   logic                      en, out_free, accept, start_ok, out_of_range;
   status_type                status_in;
   logic                      rotating_in;
   lane_ctrl_type             ctrl;
   trig_result_type           trig;
   logic signed [COORD_W-1:0] lt_h, lt_v, la_h, la_v;

   assign en        = !skid_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en || trig.busy;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign out_of_range = req_angle_degrees > ANGLE_MAX || req_angle_degrees < ANGLE_MIN;

   always_comb begin
      status_in = ST_OK;
      if (req_command == CMD_START) begin
         if (!req_has_center_first) begin
            status_in = ST_NO_FIRST;
         end else if (!req_has_center_second) begin
            status_in = ST_NO_SECOND;
         end else if (!req_has_angle) begin
            status_in = ST_NO_ANGLE;
         end else if (out_of_range) begin
            status_in = ST_ANGLE_RANGE;
         end
      end
   end

   assign start_ok = accept && req_command == CMD_START && status_in == ST_OK;

   always_comb begin
      rotation_on_in = rotation_on_ff;
      if (accept) begin
         if (start_ok) begin
            rotation_on_in = 1'b1;
         end else if (req_command == CMD_STOP) begin
            rotation_on_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (req_command)
         CMD_START: rotating_in = (status_in == ST_OK) ? 1'b1 : rotation_on_ff;
         CMD_STOP:  rotating_in = 1'b0;
         default:   rotating_in = rotation_on_ff;
      endcase
   end

   always_comb begin
      ctrl.rot      = rotation_on_ff && req_command != CMD_START && req_command != CMD_STOP;
      ctrl.center_h = center_h_ff;
      ctrl.center_v = center_v_ff;
      ctrl.cosine   = cos_ff;
      ctrl.sine     = sin_ff;
   end

   gpr_trig u_trig (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ok),
      .angle  (req_angle_degrees),
      .result (trig)
   );

   gpr_lane u_lane_target (
      .clock   (clock),
      .en      (en),
      .point_h (req_target_h),
      .point_v (req_target_v),
      .ctrl    (ctrl),
      .limit   (limit_ff),
      .out_h   (lt_h),
      .out_v   (lt_v)
   );

   gpr_lane u_lane_arc (
      .clock   (clock),
      .en      (en),
      .point_h (req_arc_h),
      .point_v (req_arc_v),
      .ctrl    (ctrl),
      .limit   (limit_ff),
      .out_h   (la_h),
      .out_v   (la_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_on_ff <= 1'b0;
         center_h_ff    <= '0;
         center_v_ff    <= '0;
         cos_ff         <= TRIG_W'(2 ** TRIG_FRAC);
         sin_ff         <= '0;
         limit_ff       <= LIMIT_W'(1);
         vld_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_vld_ff    <= 1'b0;
      end else begin
         rotation_on_ff <= rotation_on_in;
         if (start_ok) begin
            center_h_ff <= req_center_first;
            center_v_ff <= req_center_second;
         end
         if (trig.done) begin
            cos_ff <= trig.cosine;
            sin_ff <= trig.sine;
         end
         if (csr_valid) begin
            limit_ff <= csr_near_zero_limit;
         end
         if (en) begin
            vld_ff <= {vld_ff[LANE_STAGES-2:0], accept};
            if (out_free) begin
               rsp_valid_ff <= vld_ff[LANE_STAGES-1];
            end else if (vld_ff[LANE_STAGES-1]) begin
               skid_vld_ff <= 1'b1;
            end
         end else if (out_free) begin
            skid_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0]   <= status_in;
         rotg_ff[0] <= rotating_in;
         for (int i = 1; i < LANE_STAGES; i++) begin
            st_ff[i]   <= st_ff[i-1];
            rotg_ff[i] <= rotg_ff[i-1];
         end
         if (out_free) begin
            th_ff       <= lt_h;
            tv_ff       <= lt_v;
            ah_ff       <= la_h;
            av_ff       <= la_v;
            rsp_st_ff   <= st_ff[LANE_STAGES-1];
            rsp_rotg_ff <= rotg_ff[LANE_STAGES-1];
         end else begin
            sk_th_ff   <= lt_h;
            sk_tv_ff   <= lt_v;
            sk_ah_ff   <= la_h;
            sk_av_ff   <= la_v;
            sk_st_ff   <= st_ff[LANE_STAGES-1];
            sk_rotg_ff <= rotg_ff[LANE_STAGES-1];
         end
      end else if (out_free) begin
         th_ff       <= sk_th_ff;
         tv_ff       <= sk_tv_ff;
         ah_ff       <= sk_ah_ff;
         av_ff       <= sk_av_ff;
         rsp_st_ff   <= sk_st_ff;
         rsp_rotg_ff <= sk_rotg_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_target_h = th_ff;
   assign rsp_out_target_v = tv_ff;
   assign rsp_out_arc_h    = ah_ff;
   assign rsp_out_arc_v    = av_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_rotating     = rsp_rotg_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gpr_checker.sv
// Port-level checker for the plane rotation block, bound to the top level
`default_nettype none
`include "gcode_plane_rotation_macros.svh"
module gpr_checker import gpr_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic [1:0]                req_command,
   input wire logic signed [COORD_W-1:0] req_target_h,
   input wire logic signed [COORD_W-1:0] req_target_v,
   input wire logic signed [COORD_W-1:0] req_arc_h,
   input wire logic signed [COORD_W-1:0] req_arc_v,
   input wire logic signed [COORD_W-1:0] req_center_first,
   input wire logic signed [COORD_W-1:0] req_center_second,
   input wire logic signed [COORD_W-1:0] req_angle_degrees,
   input wire logic                      req_has_center_first,
   input wire logic                      req_has_center_second,
   input wire logic                      req_has_angle,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic signed [COORD_W-1:0] rsp_out_target_h,
   input wire logic signed [COORD_W-1:0] rsp_out_target_v,
   input wire logic signed [COORD_W-1:0] rsp_out_arc_h,
   input wire logic signed [COORD_W-1:0] rsp_out_arc_v,
   input wire logic [2:0]                rsp_status,
   input wire logic                      rsp_rotating,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [LIMIT_W-1:0]        csr_near_zero_limit
);

   `GPR_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response after reset")

   `GPR_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status <= ST_ANGLE_RANGE, "bad status")

   `GPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped")

   `GPR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_target_h) && $stable(rsp_out_arc_v) && $stable(rsp_status), "stalled response moved")

endmodule

bind gcode_plane_rotation gpr_checker u_gpr_checker (.*);
`default_nettype wire

// File: sim/gcode_plane_rotation_checker.sv
// Checker for the plane rotation block: predicts each result and compares it
`default_nettype none
module gcode_plane_rotation_checker import gpr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [1:0]                req_command,
   input  wire logic signed [COORD_W-1:0] req_target_h,
   input  wire logic signed [COORD_W-1:0] req_target_v,
   input  wire logic signed [COORD_W-1:0] req_arc_h,
   input  wire logic signed [COORD_W-1:0] req_arc_v,
   input  wire logic signed [COORD_W-1:0] req_center_first,
   input  wire logic signed [COORD_W-1:0] req_center_second,
   input  wire logic signed [COORD_W-1:0] req_angle_degrees,
   input  wire logic                      req_has_center_first,
   input  wire logic                      req_has_center_second,
   input  wire logic                      req_has_angle,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic signed [COORD_W-1:0] rsp_out_target_h,
   input  wire logic signed [COORD_W-1:0] rsp_out_target_v,
   input  wire logic signed [COORD_W-1:0] rsp_out_arc_h,
   input  wire logic signed [COORD_W-1:0] rsp_out_arc_v,
   input  wire logic [2:0]                rsp_status,
   input  wire logic                      rsp_rotating,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [LIMIT_W-1:0]        csr_near_zero_limit,
   output int                             mismatches,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] target_h;
      logic signed [31:0] target_v;
      logic signed [31:0] arc_h;
      logic signed [31:0] arc_v;
      status_type         status;
      logic               rotating;
   } rotated_block_type;

   rotated_block_type expected_blocks[$];

   logic              rot_on;
   longint            ctr_h, ctr_v, cos_q, sin_q;
   longint unsigned   snap_limit;

   function automatic void make_sin_cos(input longint ang, output longint s_o,
                                        output longint c_o);
      longint full, quarter, r, s, c, t;
      longint unsigned x, term;
      int q;
      bit swap;
      full = 360 * 65536;
      quarter = 90 * 65536;
      if (ang < 0) ang += full;
      if (ang >= full) ang -= full;
      q = int'(ang / quarter);
      r = ang - longint'(q) * quarter;
      swap = r > 45 * 65536;
      if (swap) r = quarter - r;
      x = (longint'(r) * 64'hC90FDAA2) / (180 * 65536);
      term = x;
      s = longint'(x);
      for (int k = 1; k <= 4; k++) begin
         term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * k) * (2 * k + 1));
         s = (k % 2) ? s - longint'(term) : s + longint'(term);
      end
      term = 64'd1 << 30;
      c = longint'(term);
      for (int k = 1; k <= 5; k++) begin
         term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * k - 1) * (2 * k));
         c = (k % 2) ? c - longint'(term) : c + longint'(term);
      end
      s = (s + (64'sd1 << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
      c = (c + (64'sd1 << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
      if (swap) begin
         t = s; s = c; c = t;
      end
      case (q)
         0: begin s_o = s;  c_o = c;  end
         1: begin s_o = c;  c_o = -s; end
         2: begin s_o = -s; c_o = -c; end
         default: begin s_o = -c; c_o = s; end
      endcase
   endfunction

   function automatic longint settle(input longint prod, input longint ctr);
      longint v, mag;
      v = (prod + (64'sd1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      mag = v < 0 ? -v : v;
      if (mag < longint'(snap_limit)) v = 0;
      v = v + ctr;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
   endfunction

   function automatic void turn_point(inout logic signed [31:0] h,
                                      inout logic signed [31:0] v);
      longint dh, dv;
      dh = longint'(h) - ctr_h;
      dv = longint'(v) - ctr_v;
      h = 32'(settle(dh * cos_q - dv * sin_q, ctr_h));
      v = 32'(settle(dh * sin_q + dv * cos_q, ctr_v));
   endfunction

   function automatic rotated_block_type predict_block();
      rotated_block_type b;
      longint ang;
      b.target_h = req_target_h;
      b.target_v = req_target_v;
      b.arc_h = req_arc_h;
      b.arc_v = req_arc_v;
      b.status = ST_OK;
      ang = longint'(req_angle_degrees);
      if (req_command == CMD_START) begin
         if (!req_has_center_first) b.status = ST_NO_FIRST;
         else if (!req_has_center_second) b.status = ST_NO_SECOND;
         else if (!req_has_angle) b.status = ST_NO_ANGLE;
         else if (ang > 360 * 65536 || ang < -360 * 65536) b.status = ST_ANGLE_RANGE;
         else begin
            ctr_h = longint'(req_center_first);
            ctr_v = longint'(req_center_second);
            make_sin_cos(ang, sin_q, cos_q);
            rot_on = 1'b1;
         end
      end else begin
         if (req_command == CMD_STOP) rot_on = 1'b0;
         if (rot_on) begin
            turn_point(b.target_h, b.target_v);
            turn_point(b.arc_h, b.arc_v);
         end
      end
      b.rotating = rot_on;
      return b;
   endfunction

   always @(posedge clock) begin
      rotated_block_type want;
      if (reset) begin
         rot_on = 1'b0;
         ctr_h = 0;
         ctr_v = 0;
         cos_q = 64'sd1 << TRIG_FRAC;
         sin_q = 0;
         snap_limit = 1;
         expected_blocks.delete();
         mismatches <= 0;
      end else begin
         if (csr_valid && csr_ready) snap_limit = csr_near_zero_limit;
         if (req_valid && !req_stall) expected_blocks.push_back(predict_block());
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               if (mismatches < 10) $display("%t unexpected result", $realtime);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_out_target_h !== want.target_h || rsp_out_target_v !== want.target_v
                   || rsp_out_arc_h !== want.arc_h || rsp_out_arc_v !== want.arc_v
                   || rsp_status !== want.status || rsp_rotating !== want.rotating) begin
                  if (mismatches < 10)
                     $display("%t mismatch: exp %h %h %h %h st %0d rot %0d, got %h %h %h %h st %0d rot %0d",
                              $realtime, want.target_h, want.target_v, want.arc_h,
                              want.arc_v, want.status, want.rotating, rsp_out_target_h,
                              rsp_out_target_v, rsp_out_arc_h, rsp_out_arc_v, rsp_status,
                              rsp_rotating);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      outstanding <= expected_blocks.size();
   end
endmodule
`default_nettype wire

// File: sim/gcode_plane_rotation_tb.sv
// Testbench top for the plane rotation block: stimulus, stalls and verdict
`default_nettype none
module gcode_plane_rotation_tb;
   import gpr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam cmd_type CMD_SPARE = 2'd3;
   localparam int      DEG = 65536;
   localparam int      CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [1:0] req_command = CMD_ORDINARY;
   logic signed [31:0] req_target_h = '0, req_target_v = '0, req_arc_h = '0, req_arc_v = '0;
   logic signed [31:0] req_center_first = '0, req_center_second = '0;
   logic signed [31:0] req_angle_degrees = '0;
   logic req_has_center_first = 1'b0, req_has_center_second = 1'b0, req_has_angle = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_target_h, rsp_out_target_v, rsp_out_arc_h, rsp_out_arc_v;
   logic [2:0] rsp_status;
   logic rsp_rotating;
   logic csr_valid = 1'b0, csr_ready;
   logic [15:0] csr_near_zero_limit = '0;
   int mismatches, outstanding;
   int cycles = 0;
   logic squeeze = 1'b0;

   always #4 clock = ~clock;

   gcode_plane_rotation dut (.*);
   gcode_plane_rotation_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stall runs, one long hold-off once asked
   initial begin
      int n;
      wait (!reset);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic send_block(input cmd_type cmd, input logic [31:0] th, tv, ah, av,
                             input logic [31:0] cf, cs, ang, input logic [2:0] has);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_target_h <= th;
      req_target_v <= tv;
      req_arc_h <= ah;
      req_arc_v <= av;
      req_center_first <= cf;
      req_center_second <= cs;
      req_angle_degrees <= ang;
      req_has_center_first <= has[2];
      req_has_center_second <= has[1];
      req_has_angle <= has[0];
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      if (r < 16) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return 32'hffffffff;
         endcase
      end
      return $urandom_range(0, 32'h07ffffff) - 32'h04000000;
   endfunction

   function automatic logic [31:0] pick_angle();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 16) - 8) * 45 * DEG;
      return $urandom_range(0, 720 * DEG) - 360 * DEG;
   endfunction

   task automatic random_block();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)
         send_block(CMD_START, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_angle(), 3'b111);
      else if (r < 8)
         send_block(CMD_START, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), $urandom, 3'($urandom));
      else if (r < 12)
         send_block(CMD_STOP, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    $urandom, $urandom, $urandom, 3'($urandom));
      else
         send_block(r < 15 ? CMD_SPARE : CMD_ORDINARY, pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), $urandom, $urandom, $urandom,
                    3'($urandom));
   endtask

   task automatic settle_and_write(input logic [15:0] limit);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_near_zero_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] limits[4];
      limits = '{16'd0, 16'hffff, 16'($urandom), 16'd1};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_block(CMD_ORDINARY, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                 0, 0, 0, 3'b000);
      send_block(CMD_START, 1, 2, 3, 4, 0, 0, 30 * DEG, 3'b011);
      send_block(CMD_START, 1, 2, 3, 4, 0, 0, 30 * DEG, 3'b101);
      send_block(CMD_START, 1, 2, 3, 4, 0, 0, 30 * DEG, 3'b110);
      send_block(CMD_START, 1, 2, 3, 4, 0, 0, 360 * DEG + 1, 3'b111);
      send_block(CMD_START, 1, 2, 3, 4, 0, 0, -360 * DEG - 1, 3'b111);
      send_block(CMD_START, 0, 0, 0, 0, 32'h00010000, 32'hfffe0000, 360 * DEG, 3'b111);
      send_block(CMD_ORDINARY, 32'h00050000, 32'h00030000, 32'h0, 32'h0, 0, 0, 0, 3'b000);
      send_block(CMD_START, 0, 0, 0, 0, 0, 0, -360 * DEG, 3'b111);
      send_block(CMD_ORDINARY, 32'h7fffffff, 32'h80000000, 1, -1, 0, 0, 0, 3'b000);
      send_block(CMD_START, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 90 * DEG, 3'b111);
      send_block(CMD_ORDINARY, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 0, 0, 0, 3'b000);
      send_block(CMD_START, 0, 0, 0, 0, 0, 0, 45 * DEG, 3'b111);
      send_block(CMD_ORDINARY, 32'h00010000, 0, 1, 1, 0, 0, 0, 3'b000);
      send_block(CMD_START, 0, 0, 0, 0, 0, 0, 180 * DEG, 3'b111);
      send_block(CMD_SPARE, 32'h00020000, 32'h00010000, 32'h7fffffff, 32'h7fffffff,
                 0, 0, 0, 3'b000);
      send_block(CMD_START, 0, 0, 0, 0, 32'h12340000, 32'hedcc0000, 270 * DEG, 3'b111);
      send_block(CMD_ORDINARY, 32'h0, 32'h0, 32'hffffffff, 32'h80000000, 0, 0, 0, 3'b000);
      send_block(CMD_STOP, 32'h00020000, 32'h00010000, 5, 6, 0, 0, 0, 3'b111);
      send_block(CMD_ORDINARY, 32'h00020000, 32'h00010000, 5, 6, 0, 0, 0, 3'b000);

      for (int phase = 0; phase < 4; phase++) begin
         settle_and_write(limits[phase]);
         if (phase == 1) squeeze = 1'b1;
         repeat (210) random_block();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_trig.sv
hw/rtl/gpr_lane.sv
hw/rtl/gcode_plane_rotation.sv
hw/rtl/gpr_checker.sv
sim/gcode_plane_rotation_checker.sv
sim/gcode_plane_rotation_tb.sv
